/* rtl/json_key_value_extractor_assert.svh */
// Assertion macros for the JSON key/value extractor checker.
// Expects signals clk and rst_n in the scope of use.
`ifndef JSON_KEY_VALUE_EXTRACTOR_ASSERT_SVH
`define JSON_KEY_VALUE_EXTRACTOR_ASSERT_SVH
// same-cycle implication
`define JKVE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define JKVE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* rtl/jkve_pkg.sv */
// Types, constants and per-byte parse functions of the JSON key/value extractor.
// No dependencies.
package jkve_pkg;

    localparam int MAX_KEY_BYTES = 16;
    localparam int MAX_OUT_BYTES = 4095;
    localparam logic [15:0] MAX_DEPTH = 16'hFFFF;

    localparam logic [2:0] REG_KEY_LOW  = 3'd0;
    localparam logic [2:0] REG_KEY_HIGH = 3'd1;
    localparam logic [2:0] REG_KEY_LEN  = 3'd2;
    localparam logic [2:0] REG_MODE     = 3'd3;
    localparam logic [2:0] REG_LIMIT    = 3'd4;

    localparam logic [1:0] MODE_STR = 2'd0;
    localparam logic [1:0] MODE_INT = 2'd1;
    localparam logic [1:0] MODE_RAW = 2'd2;

    localparam logic [1:0] ST_FOUND    = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FORM     = 2'd2;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    localparam logic [31:0] INT_MIN_MAG = 32'h8000_0000;
    localparam logic [31:0] INT_MAX     = 32'h7FFF_FFFF;

    typedef enum logic [3:0] {
        PH_START, PH_MEMBER, PH_KEY, PH_AFTER_KEY, PH_BEFORE_VALUE,
        PH_SKIP_STR, PH_SKIP_NEST, PH_SKIP_SCALAR, PH_STR_EX, PH_INT, PH_DONE
    } phase_t;

    typedef struct packed {
        logic [63:0] key_low;
        logic [63:0] key_high;
        logic [4:0]  key_length;
        logic [1:0]  extract_mode;
        logic [11:0] out_limit;
    } cfg_t;

    typedef struct packed {
        phase_t      phase;
        logic [15:0] depth;
        logic        is_array;
        logic        in_str;
        logic [4:0]  key_pos;
        logic        key_match;
        logic        esc;
        logic [11:0] emit_cnt;
        logic [31:0] acc;
        logic        neg;
        logic        digit_seen;
    } pstate_t;

    typedef struct packed {
        pstate_t    st;
        logic       again;
        logic       emit;
        logic [7:0] ebyte;
        logic       fin;
        logic [1:0] status;
    } pass_t;

    typedef struct packed {
        logic              kind;
        logic [7:0]        byte_v;
        logic [1:0]        status;
        logic signed [31:0] int_v;
        logic              last;
    } result_t;

    localparam pstate_t PSTATE_RESET = '{
        phase: PH_START, depth: 16'd0, is_array: 1'b0, in_str: 1'b0, key_pos: 5'd0,
        key_match: 1'b1, esc: 1'b0, emit_cnt: 12'd0, acc: 32'd0, neg: 1'b0,
        digit_seen: 1'b0
    };

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);
    endfunction

    function automatic logic [7:0] key_byte(input cfg_t cfg, input logic [3:0] i);
        logic [127:0] k;
        k = {cfg.key_high, cfg.key_low};
        return k[{i, 3'b000} +: 8];
    endfunction

    function automatic pass_t do_emit(input pass_t p, input logic [7:0] v,
                                      input cfg_t cfg);
        pass_t r;
        r = p;
        if (r.st.emit_cnt < cfg.out_limit) begin
            r.emit = 1'b1;
            r.ebyte = v;
            r.st.emit_cnt = r.st.emit_cnt + 12'd1;
        end
        return r;
    endfunction

    function automatic pass_t do_fin(input pass_t p, input logic [1:0] s);
        pass_t r;
        r = p;
        r.fin = 1'b1;
        r.status = s;
        r.st.phase = PH_DONE;
        return r;
    endfunction

    function automatic pass_t key_cmp(input pass_t p, input logic [7:0] c, input cfg_t cfg);
        pass_t r;
        r = p;
        if (!((r.st.key_pos < cfg.key_length) && (r.st.key_pos < 5'(MAX_KEY_BYTES))
              && (c == key_byte(cfg, r.st.key_pos[3:0]))))
            r.st.key_match = 1'b0;
        if (r.st.key_pos != 5'd31)
            r.st.key_pos = r.st.key_pos + 5'd1;
        return r;
    endfunction

    function automatic pass_t end_skip(input pass_t p);
        pass_t r;
        r = p;
        if (r.st.key_match)
            r = do_fin(r, ST_FOUND);
        else
            r.st.phase = PH_MEMBER;
        return r;
    endfunction

    function automatic pass_t start_value(input pass_t p, input logic [7:0] c,
                                          input logic extracting, input cfg_t cfg);
        pass_t r;
        r = p;
        r.st.esc = 1'b0;
        r.st.in_str = 1'b0;
        if (c == "\"") begin
            r.st.phase = PH_SKIP_STR;
            if (extracting) r = do_emit(r, c, cfg);
        end else if (c == "{" || c == "[") begin
            r.st.phase = PH_SKIP_NEST;
            r.st.depth = 16'd1;
            r.st.is_array = (c == "[");
            if (extracting) r = do_emit(r, c, cfg);
        end else begin
            r.st.phase = PH_SKIP_SCALAR;
            r.again = 1'b1;
        end
        return r;
    endfunction

    // One pass of the byte through the phase machine.
    function automatic pass_t parse_pass(input pstate_t s, input logic [7:0] c,
                                         input cfg_t cfg);
        pass_t r;
        logic ws;
        logic x;
        logic [35:0] t;
        r = '0;
        r.st = s;
        ws = is_ws(c);
        x = s.key_match;
        t = ({4'd0, s.acc} << 3) + ({4'd0, s.acc} << 1) + {32'd0, c[3:0] - 4'd0};
        case (s.phase)
            PH_START: begin
                if (!ws) begin
                    if (c == "{") r.st.phase = PH_MEMBER;
                    else r = do_fin(r, ST_NOTFOUND);
                end
            end
            PH_MEMBER: begin
                if (!(ws || c == ",")) begin
                    if (c == "\"") begin
                        r.st.phase = PH_KEY;
                        r.st.key_pos = 5'd0;
                        r.st.key_match = 1'b1;
                        r.st.esc = 1'b0;
                    end else begin
                        r = do_fin(r, ST_NOTFOUND);
                    end
                end
            end
            PH_KEY: begin
                if (s.esc) begin
                    r.st.esc = 1'b0;
                    r = key_cmp(r, c, cfg);
                end else if (c == "\"") begin
                    r.st.key_match = s.key_match && (s.key_pos == cfg.key_length);
                    r.st.phase = PH_AFTER_KEY;
                end else begin
                    if (c == "\\") r.st.esc = 1'b1;
                    r = key_cmp(r, c, cfg);
                end
            end
            PH_AFTER_KEY: begin
                if (!ws) begin
                    r.st.phase = PH_BEFORE_VALUE;
                    r.again = (c != ":");
                end
            end
            PH_BEFORE_VALUE: begin
                if (!ws) begin
                    if (!s.key_match) begin
                        r = start_value(r, c, 1'b0, cfg);
                    end else begin
                        case (cfg.extract_mode)
                            MODE_STR: begin
                                if (c == "\"") begin
                                    r.st.phase = PH_STR_EX;
                                    r.st.esc = 1'b0;
                                end else begin
                                    r = do_fin(r, ST_FORM);
                                end
                            end
                            MODE_INT: begin
                                r.st.acc = 32'd0;
                                r.st.digit_seen = 1'b0;
                                r.st.neg = (c == "-");
                                r.st.phase = PH_INT;
                                r.again = !(c == "+" || c == "-");
                            end
                            MODE_RAW: r = start_value(r, c, 1'b1, cfg);
                            default: r = do_fin(r, ST_FORM);
                        endcase
                    end
                end
            end
            PH_SKIP_STR: begin
                if (x) r = do_emit(r, c, cfg);
                if (s.esc) r.st.esc = 1'b0;
                else if (c == "\\") r.st.esc = 1'b1;
                else if (c == "\"") r = end_skip(r);
            end
            PH_SKIP_NEST: begin
                if (x) r = do_emit(r, c, cfg);
                if (s.in_str) begin
                    if (s.esc) r.st.esc = 1'b0;
                    else if (c == "\\") r.st.esc = 1'b1;
                    else if (c == "\"") r.st.in_str = 1'b0;
                end else if (c == (s.is_array ? 8'h5B : 8'h7B)) begin
                    if (s.depth < MAX_DEPTH) r.st.depth = s.depth + 16'd1;
                end else if (c == (s.is_array ? 8'h5D : 8'h7D)) begin
                    r.st.depth = s.depth - 16'd1;
                    if (s.depth == 16'd1) r = end_skip(r);
                end else if (c == "\"") begin
                    r.st.in_str = 1'b1;
                    r.st.esc = 1'b0;
                end
            end
            PH_SKIP_SCALAR: begin
                if (c == "," || c == "}" || c == "]" || ws) begin
                    r = end_skip(r);
                    r.again = !x;
                end else if (x) begin
                    r = do_emit(r, c, cfg);
                end
            end
            PH_STR_EX: begin
                if (s.esc) begin
                    r.st.esc = 1'b0;
                    r = do_emit(r, (c == "n") ? 8'd10 : (c == "r") ? 8'd13 :
                                   (c == "t") ? 8'd9 : c, cfg);
                end else if (c == "\\") begin
                    r.st.esc = 1'b1;
                end else if (c == "\"") begin
                    r = do_fin(r, ST_FOUND);
                end else begin
                    r = do_emit(r, c, cfg);
                end
            end
            PH_INT: begin
                if (c >= "0" && c <= "9") begin
                    r.st.acc = (t > {4'd0, INT_MIN_MAG}) ? INT_MIN_MAG : t[31:0];
                    r.st.digit_seen = 1'b1;
                end else begin
                    r = do_fin(r, s.digit_seen ? ST_FOUND : ST_FORM);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Completion status at message end; fin low when already complete.
    function automatic pass_t end_msg(input pstate_t s, input cfg_t cfg);
        pass_t r;
        logic km;
        r = '0;
        r.st = s;
        km = s.key_match;
        if (s.phase == PH_KEY) km = s.key_match && (s.key_pos == cfg.key_length);
        case (s.phase)
            PH_KEY, PH_AFTER_KEY, PH_BEFORE_VALUE:
                r = do_fin(r, !km ? ST_NOTFOUND :
                              (cfg.extract_mode == MODE_RAW) ? ST_FOUND : ST_FORM);
            PH_SKIP_STR, PH_SKIP_NEST, PH_SKIP_SCALAR:
                r = do_fin(r, km ? ST_FOUND : ST_NOTFOUND);
            PH_STR_EX: r = do_fin(r, ST_FOUND);
            PH_INT: r = do_fin(r, s.digit_seen ? ST_FOUND : ST_FORM);
            PH_DONE: ;
            default: r = do_fin(r, ST_NOTFOUND);
        endcase
        return r;
    endfunction

endpackage

/* rtl/json_key_value_extractor.sv */
// One message byte per transfer, one cycle each while the result queue can take its results; a byte
// that gives a value byte and a completion in the same step occupies the two-entry result queue
// and the input waits while both leave. Byte zero or in_last ends the message and returns the
// parser to its start. Registers at byte addresses 8*i: key_low, key_high, key_length,
// extract_mode, out_limit. Depends on jkve_pkg, jkve_core, jkve_outq.
module json_key_value_extractor
    import jkve_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        out_kind,
    output logic [7:0]  out_byte,
    output logic [1:0]  out_status,
    output logic signed [31:0] out_int,
    output logic        out_last
);

    cfg_t       cfg_reg;
    result_t    r0;
    result_t    r1;
    result_t    head;
    logic [1:0] rcnt;
    logic       take;
    logic       can_push;
    logic       wr;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{key_low: 64'd0, key_high: 64'd0, key_length: 5'd0,
                         extract_mode: MODE_STR, out_limit: 12'd255};
        end
        else if (wr)
        begin
            case (paddr[5:3])
                REG_KEY_LOW:  cfg_reg.key_low <= pwdata;
                REG_KEY_HIGH: cfg_reg.key_high <= pwdata;
                REG_KEY_LEN:  cfg_reg.key_length <= pwdata[4:0];
                REG_MODE:     cfg_reg.extract_mode <= pwdata[1:0];
                REG_LIMIT:    cfg_reg.out_limit <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[5:3])
            REG_KEY_LOW:  prdata = cfg_reg.key_low;
            REG_KEY_HIGH: prdata = cfg_reg.key_high;
            REG_KEY_LEN:  prdata = {59'd0, cfg_reg.key_length};
            REG_MODE:     prdata = {62'd0, cfg_reg.extract_mode};
            REG_LIMIT:    prdata = {52'd0, cfg_reg.out_limit};
            default:      prdata = 64'd0;
        endcase
    end

    assign in_ready = can_push;
    assign take = in_valid && can_push;

    jkve_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .take    (take),
        .in_byte (in_byte),
        .in_last (in_last),
        .res0    (r0),
        .res1    (r1),
        .res_cnt (rcnt)
    );

    jkve_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (take),
        .push0     (r0),
        .push1     (r1),
        .push_cnt  (rcnt),
        .can_push  (can_push),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign out_kind = head.kind;
    assign out_byte = head.byte_v;
    assign out_status = head.status;
    assign out_int = head.int_v;
    assign out_last = head.last;

endmodule

/* rtl/jkve_core.sv */
// Parse state register and per-byte update of the JSON key/value extractor.
// Depends on jkve_pkg.
module jkve_core
    import jkve_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       take,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output result_t    res0,
    output result_t    res1,
    output logic [1:0] res_cnt
);

    pstate_t st_reg;
    pstate_t st_next;
    pass_t   p [4];
    pass_t   em;
    logic    emit;
    logic [7:0] ebyte;
    logic    fin;
    logic [1:0] status;
    logic    ends;
    logic [31:0] iv;
    result_t rb;
    result_t rf;

    always_comb
    begin
        p[0] = parse_pass(st_reg, in_byte, cfg);
        for (int i = 1; i < 4; i++)
        begin
            if (p[i-1].again) p[i] = parse_pass(p[i-1].st, in_byte, cfg);
            else p[i] = p[i-1];
            p[i].again = p[i-1].again && p[i].again;
            p[i].emit = p[i-1].emit | (p[i-1].again & p[i].emit);
            if (p[i-1].emit) p[i].ebyte = p[i-1].ebyte;
            if (p[i-1].fin) p[i].status = p[i-1].status;
            p[i].fin = p[i-1].fin | (p[i-1].again & p[i].fin);
        end
        if (in_byte == 8'd0)
        begin
            emit = 1'b0;
            ebyte = 8'd0;
            fin = 1'b0;
            status = ST_FOUND;
            em = end_msg(st_reg, cfg);
        end
        else
        begin
            emit = p[3].emit;
            ebyte = p[3].ebyte;
            fin = p[3].fin;
            status = p[3].status;
            em = end_msg(p[3].st, cfg);
        end
        ends = (in_byte == 8'd0) || in_last;
        if (ends && em.fin)
        begin
            fin = 1'b1;
            status = em.status;
        end
        st_next = ends ? PSTATE_RESET : p[3].st;
        if (em.st.neg)
            iv = (em.st.acc >= INT_MIN_MAG) ? INT_MIN_MAG : (32'd0 - em.st.acc);
        else
            iv = (em.st.acc > INT_MAX) ? INT_MAX : em.st.acc;
        rb = '{kind: KIND_BYTE, byte_v: ebyte, status: ST_FOUND, int_v: 32'sd0,
               last: !fin};
        rf = '{kind: KIND_DONE, byte_v: 8'd0, status: status,
               int_v: ((status == ST_FOUND) && (cfg.extract_mode == MODE_INT)) ?
                      signed'(iv) : 32'sd0,
               last: 1'b1};
        res0 = emit ? rb : rf;
        res1 = rf;
        res_cnt = {1'b0, emit} + {1'b0, fin};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) st_reg <= PSTATE_RESET;
        else if (take) st_reg <= st_next;
    end

endmodule

/* rtl/jkve_outq.sv */
// Two-entry result queue: holds the results of one byte and drives the output.
// Depends on jkve_pkg.
module jkve_outq
    import jkve_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  result_t    push0,
    input  result_t    push1,
    input  logic [1:0] push_cnt,
    output logic       can_push,
    output logic       out_valid,
    input  logic       out_ready,
    output result_t    head
);

    result_t    q0_reg;
    result_t    q1_reg;
    logic [1:0] cnt_reg;
    logic       pop;

    assign out_valid = (cnt_reg != 2'd0);
    assign pop = out_valid && out_ready;
    assign can_push = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && out_ready);
    assign head = q0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) cnt_reg <= 2'd0;
        else if (push) cnt_reg <= push_cnt;
        else if (pop) cnt_reg <= cnt_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q0_reg <= push0;
            q1_reg <= push1;
        end
        else if (pop)
        begin
            q0_reg <= q1_reg;
        end
    end

endmodule

/* rtl/jkve_checker.sv */
// Port-level checks of the JSON key/value extractor, bound to the top level.
// Depends on json_key_value_extractor_assert.svh.
`include "json_key_value_extractor_assert.svh"
module jkve_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        out_kind,
    input logic [7:0]  out_byte,
    input logic [1:0]  out_status,
    input logic [31:0] out_int,
    input logic        out_last
);

    `JKVE_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte))
    `JKVE_ASSERT_NOW(a_byte_clean, out_valid && !out_kind, out_status == 2'd0 && out_int == 32'd0)
    `JKVE_ASSERT_NOW(a_done_clean, out_valid && out_kind, out_byte == 8'd0 && out_last)
    `JKVE_ASSERT_NOW(a_fail_noint, out_valid && out_kind && out_status != 2'd0, out_int == 32'd0)

endmodule

bind json_key_value_extractor jkve_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_kind   (out_kind),
    .out_byte   (out_byte),
    .out_status (out_status),
    .out_int    (out_int),
    .out_last   (out_last)
);

/* dv/tb_top.sv */
// Self-checking testbench for json_key_value_extractor: streams JSON messages, predicts
// every value byte and completion, and checks the results in order. Depends on jkve_pkg.
`timescale 1ns / 1ps

module tb_top;
    import jkve_pkg::*;

    localparam int WD_LIMIT = 4000;

    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    logic        in_valid, in_ready, in_last;
    logic [7:0]  in_byte;
    logic        out_valid, out_ready, out_kind, out_last;
    logic [7:0]  out_byte;
    logic [1:0]  out_status;
    logic signed [31:0] out_int;

    json_key_value_extractor dut (.*);

    // register copies
    logic [127:0] key_bits;
    logic [4:0]   key_len;
    logic [1:0]   xmode;
    logic [11:0]  byte_limit;

    // parser copy
    phase_t      ph;
    logic [15:0] nest;
    logic        nest_arr, nest_str;
    logic [4:0]  kpos;
    logic        kmatch, esc_p;
    logic [11:0] n_emit;
    logic [31:0] mag;
    logic        neg, seen_digit;

    result_t     expected_q[$];
    logic [7:0]  msg_buf[$];
    int          errors;
    int          idle_cycles;
    bit          quiet;
    int          rx_stall;
    int          n_sent;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void clear_parser();
        ph = PH_START;
        nest = '0;
        nest_arr = 1'b0;
        nest_str = 1'b0;
        kpos = '0;
        kmatch = 1'b1;
        esc_p = 1'b0;
        n_emit = '0;
        mag = '0;
        neg = 1'b0;
        seen_digit = 1'b0;
    endfunction

    function automatic void push_result(logic k, logic [7:0] b, logic [1:0] s,
                                        logic [31:0] v);
        result_t r;
        r.kind = k;
        r.byte_v = b;
        r.status = s;
        r.int_v = v;
        r.last = 1'b0;
        expected_q.push_back(r);
    endfunction

    function automatic void emit_byte(logic [7:0] b);
        if (n_emit < byte_limit) begin
            push_result(KIND_BYTE, b, ST_FOUND, 32'd0);
            n_emit++;
        end
    endfunction

    function automatic void complete(logic [1:0] s);
        logic [31:0] v;
        v = 32'd0;
        if (s == ST_FOUND && xmode == MODE_INT) begin
            if (neg) v = (mag >= INT_MIN_MAG) ? INT_MIN_MAG : -mag;
            else v = (mag > INT_MAX) ? INT_MAX : mag;
        end
        push_result(KIND_DONE, 8'd0, s, v);
        ph = PH_DONE;
    endfunction

    function automatic void key_step(logic [7:0] c);
        if (!(kpos < key_len && kpos < 5'd16 && c == key_bits[{kpos[3:0], 3'b000} +: 8]))
            kmatch = 1'b0;
        if (kpos != 5'd31) kpos++;
    endfunction

    function automatic void value_done();
        if (kmatch) complete(ST_FOUND);
        else ph = PH_MEMBER;
    endfunction

    function automatic bit open_value(logic [7:0] c, bit extracting);
        esc_p = 1'b0;
        nest_str = 1'b0;
        if (c == "\"") begin
            ph = PH_SKIP_STR;
        end else if (c == "{" || c == "[") begin
            ph = PH_SKIP_NEST;
            nest = 16'd1;
            nest_arr = (c == "[");
        end else begin
            ph = PH_SKIP_SCALAR;
            return 1'b1;
        end
        if (extracting) emit_byte(c);
        return 1'b0;
    endfunction

    // one pass of a byte; returns 1 when the byte must be taken again
    function automatic bit parse_pass(logic [7:0] c);
        logic ws, x;
        logic [63:0] t;
        ws = (c == " " || c == "\t" || c == "\n" || c == "\r");
        x = kmatch;
        case (ph)
            PH_START:
                if (!ws) begin
                    if (c == "{") ph = PH_MEMBER;
                    else complete(ST_NOTFOUND);
                end
            PH_MEMBER:
                if (!(ws || c == ",")) begin
                    if (c == "\"") begin
                        ph = PH_KEY;
                        kpos = '0;
                        kmatch = 1'b1;
                        esc_p = 1'b0;
                    end else begin
                        complete(ST_NOTFOUND);
                    end
                end
            PH_KEY:
                if (esc_p) begin
                    esc_p = 1'b0;
                    key_step(c);
                end else if (c == "\"") begin
                    kmatch = kmatch && (kpos == key_len);
                    ph = PH_AFTER_KEY;
                end else begin
                    if (c == "\\") esc_p = 1'b1;
                    key_step(c);
                end
            PH_AFTER_KEY:
                if (!ws) begin
                    ph = PH_BEFORE_VALUE;
                    if (c != ":") return 1'b1;
                end
            PH_BEFORE_VALUE:
                if (!ws) begin
                    if (!kmatch) return open_value(c, 1'b0);
                    case (xmode)
                        MODE_STR:
                            if (c == "\"") begin
                                ph = PH_STR_EX;
                                esc_p = 1'b0;
                            end else begin
                                complete(ST_FORM);
                            end
                        MODE_INT: begin
                            mag = '0;
                            seen_digit = 1'b0;
                            neg = (c == "-");
                            ph = PH_INT;
                            if (c != "+" && c != "-") return 1'b1;
                        end
                        MODE_RAW: return open_value(c, 1'b1);
                        default: complete(ST_FORM);
                    endcase
                end
            PH_SKIP_STR: begin
                if (x) emit_byte(c);
                if (esc_p) esc_p = 1'b0;
                else if (c == "\\") esc_p = 1'b1;
                else if (c == "\"") value_done();
            end
            PH_SKIP_NEST: begin
                if (x) emit_byte(c);
                if (nest_str) begin
                    if (esc_p) esc_p = 1'b0;
                    else if (c == "\\") esc_p = 1'b1;
                    else if (c == "\"") nest_str = 1'b0;
                end else if (c == (nest_arr ? 8'h5B : 8'h7B)) begin
                    if (nest != 16'hFFFF) nest++;
                end else if (c == (nest_arr ? 8'h5D : 8'h7D)) begin
                    nest--;
                    if (nest == 16'd0) value_done();
                end else if (c == "\"") begin
                    nest_str = 1'b1;
                    esc_p = 1'b0;
                end
            end
            PH_SKIP_SCALAR:
                if (c == "," || c == "}" || c == "]" || ws) begin
                    value_done();
                    return !x;
                end else if (x) begin
                    emit_byte(c);
                end
            PH_STR_EX:
                if (esc_p) begin
                    esc_p = 1'b0;
                    emit_byte(c == "n" ? 8'd10 : c == "r" ? 8'd13 : c == "t" ? 8'd9 : c);
                end else if (c == "\\") begin
                    esc_p = 1'b1;
                end else if (c == "\"") begin
                    complete(ST_FOUND);
                end else begin
                    emit_byte(c);
                end
            PH_INT:
                if (c >= "0" && c <= "9") begin
                    t = 64'(mag) * 10 + 64'(c - "0");
                    mag = (t > 64'(INT_MIN_MAG)) ? INT_MIN_MAG : t[31:0];
                    seen_digit = 1'b1;
                end else begin
                    complete(seen_digit ? ST_FOUND : ST_FORM);
                end
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic void message_end();
        if (ph == PH_KEY) kmatch = kmatch && (kpos == key_len);
        case (ph)
            PH_KEY, PH_AFTER_KEY, PH_BEFORE_VALUE:
                complete(!kmatch ? ST_NOTFOUND : (xmode == MODE_RAW) ? ST_FOUND : ST_FORM);
            PH_SKIP_STR, PH_SKIP_NEST, PH_SKIP_SCALAR:
                complete(kmatch ? ST_FOUND : ST_NOTFOUND);
            PH_STR_EX: complete(ST_FOUND);
            PH_INT: complete(seen_digit ? ST_FOUND : ST_FORM);
            PH_DONE: ;
            default: complete(ST_NOTFOUND);
        endcase
        clear_parser();
    endfunction

    function automatic void predict_byte(logic [7:0] c, logic lst);
        int first;
        first = expected_q.size();
        if (c != 8'd0) begin
            for (int g = 0; g < 4; g++)
                if (!parse_pass(c)) break;
        end
        if (c == 8'd0 || lst) message_end();
        if (expected_q.size() > first) expected_q[$].last = 1'b1;
    endfunction

    // transfer monitor, checker and watchdog
    always @(posedge clk) begin
        result_t e;
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (in_valid && in_ready) predict_byte(in_byte, in_last);
            if (out_valid && out_ready) begin
                if (expected_q.size() == 0) begin
                    $error("unexpected result kind %0h byte %0h", out_kind, out_byte);
                    errors++;
                end else begin
                    e = expected_q.pop_front();
                    if (out_kind !== e.kind) begin
                        $error("out_kind exp %0h got %0h", e.kind, out_kind); errors++;
                    end
                    if (out_byte !== e.byte_v) begin
                        $error("out_byte exp %0h got %0h", e.byte_v, out_byte); errors++;
                    end
                    if (out_status !== e.status) begin
                        $error("out_status exp %0h got %0h", e.status, out_status); errors++;
                    end
                    if (out_int !== e.int_v) begin
                        $error("out_int exp %0d got %0d", e.int_v, out_int); errors++;
                    end
                    if (out_last !== e.last) begin
                        $error("out_last exp %0h got %0h", e.last, out_last); errors++;
                    end
                end
            end
            if (idle_cycles >= WD_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // receiver stalls
    always @(posedge clk) begin
        if (!rst_n || quiet) begin
            out_ready <= 1'b1;
        end else if (rx_stall > 0) begin
            out_ready <= 1'b0;
            rx_stall--;
        end else begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 7) == 0) rx_stall = $urandom_range(1, 16);
        end
    end

    task automatic wait_drained();
        @(posedge clk);
        while (expected_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic reg_write(logic [2:0] idx, logic [63:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
    endtask

    task automatic configure(logic [127:0] k, logic [4:0] len, logic [1:0] m,
                             logic [11:0] lim);
        in_valid <= 1'b0;
        wait_drained();
        reg_write(REG_KEY_LOW, k[63:0]);
        reg_write(REG_KEY_HIGH, k[127:64]);
        reg_write(REG_KEY_LEN, 64'(len));
        reg_write(REG_MODE, 64'(m));
        reg_write(REG_LIMIT, 64'(lim));
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        key_bits = k;
        key_len = len;
        xmode = m;
        byte_limit = lim;
    endtask

    task automatic send_byte(logic [7:0] b, logic lst);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte <= b;
        in_last <= lst;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        n_sent++;
    endtask

    // sends msg_buf; ends it with in_last or with a zero byte
    task automatic send_message(bit zero_end);
        int n;
        n = msg_buf.size();
        for (int i = 0; i < n; i++)
            send_byte(msg_buf[i], !zero_end && i == n - 1);
        if (zero_end || n == 0) send_byte(8'd0, 1'($urandom_range(0, 1)));
        msg_buf.delete();
    endtask

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++) msg_buf.push_back(s[i]);
    endfunction

    task automatic send_text(string s, bit zero_end);
        add_text(s);
        send_message(zero_end);
    endtask

    function automatic logic [127:0] pack_key(string s);
        logic [127:0] k;
        k = '0;
        for (int i = 0; i < s.len() && i < 16; i++) k[8*i +: 8] = s[i];
        return k;
    endfunction

    function automatic void add_blank();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) msg_buf.push_back(" ");
        else if (r == 1) msg_buf.push_back("\t");
        else if (r == 2) msg_buf.push_back("\n");
        else if (r == 3) msg_buf.push_back("\r");
    endfunction

    function automatic void add_key(bit hit);
        int n;
        msg_buf.push_back("\"");
        if (hit) begin
            n = (key_len > 16) ? 16 : key_len;
            for (int i = 0; i < n; i++) msg_buf.push_back(key_bits[8*i +: 8]);
        end else begin
            n = $urandom_range(0, 5);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 9) == 0) msg_buf.push_back("\\");
                msg_buf.push_back(8'("a" + $urandom_range(0, 3)));
            end
        end
        msg_buf.push_back("\"");
    endfunction

    function automatic void add_string_body();
        logic [7:0] c;
        int n;
        n = $urandom_range(0, 8);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 4) == 0) begin
                msg_buf.push_back("\\");
                case ($urandom_range(0, 6))
                    0: c = "n";
                    1: c = "r";
                    2: c = "t";
                    3: c = "\"";
                    4: c = "\\";
                    5: c = "/";
                    default: c = 8'($urandom_range(1, 255));
                endcase
            end else begin
                do c = 8'($urandom_range(1, 255)); while (c == "\"" || c == "\\");
            end
            msg_buf.push_back(c);
        end
        msg_buf.push_back("\"");
    endfunction

    function automatic void add_value(int lvl);
        int n;
        bit arr;
        case ($urandom_range(0, 5))
            0, 1: begin
                msg_buf.push_back("\"");
                add_string_body();
            end
            2: begin
                n = $urandom_range(0, 2);
                if (n == 1) msg_buf.push_back("-");
                if (n == 2) msg_buf.push_back("+");
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 14) : $urandom_range(0, 4);
                for (int i = 0; i < n; i++) msg_buf.push_back(8'("0" + $urandom_range(0, 9)));
            end
            3: add_text($urandom_range(0, 1) ? "true" : "null");
            4: begin
                if (lvl >= 2) begin
                    add_text("7");
                    return;
                end
                arr = 1'($urandom_range(0, 1));
                msg_buf.push_back(arr ? "[" : "{");
                n = $urandom_range(0, 3);
                for (int i = 0; i < n; i++) begin
                    if (i > 0) msg_buf.push_back(",");
                    add_blank();
                    if (!arr) begin
                        add_key(1'b0);
                        msg_buf.push_back(":");
                    end
                    add_value(lvl + 1);
                end
                msg_buf.push_back(arr ? "]" : "}");
            end
            default: msg_buf.push_back(8'($urandom_range(1, 255)));
        endcase
    endfunction

    // object with random members and values, at times without a colon, sometimes cut short
    task automatic send_random_object();
        int n, hit_at, cut;
        n = $urandom_range(1, 4);
        hit_at = $urandom_range(0, n);
        add_blank();
        msg_buf.push_back("{");
        for (int i = 0; i < n; i++) begin
            if (i > 0) msg_buf.push_back(",");
            add_blank();
            add_key(i == hit_at);
            add_blank();
            if ($urandom_range(0, 9) != 0) msg_buf.push_back(":");
            add_blank();
            add_value(0);
            add_blank();
        end
        msg_buf.push_back("}");
        if ($urandom_range(0, 6) == 0) begin
            cut = $urandom_range(1, msg_buf.size());
            while (msg_buf.size() > cut) void'(msg_buf.pop_back());
        end
        send_message($urandom_range(0, 2) == 0);
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 10)) msg_buf.push_back(8'($urandom_range(1, 255)));
        send_message(1'($urandom_range(0, 1)));
    endtask

    task automatic test_string_mode();
        configure(pack_key("name"), 5'd4, MODE_STR, 12'd255);
        send_text("{\"name\":\"a\\nb\\r\\t\\\"\\\\\\/\\q\"}", 1'b0);
        send_text(" \t{\"nam\":1,\r\n\"name\" \"xy\"}", 1'b1);
        send_text("{\"name\":42}", 1'b0);
        send_text("[1]", 1'b0);
        send_text("{\"other\":\"v\"}", 1'b0);
        send_text("{\"name\":\"cut", 1'b0);
    endtask

    task automatic test_int_mode();
        configure(pack_key("n"), 5'd1, MODE_INT, 12'd255);
        send_text("{\"n\":-2147483649}", 1'b0);
        send_text("{\"n\":+99999999999,", 1'b1);
        send_text("{\"n\":2147483647}", 1'b0);
        send_text("{\"n\":-x}", 1'b0);
        send_text("{\"n\":17", 1'b0);
        send_text("{\"n\":", 1'b0);
    endtask

    task automatic test_raw_mode();
        configure(128'd0, 5'd0, MODE_RAW, 12'd4095);
        send_text("{\"\":[1,[\"]\\\"\",2]],\"b\":0}", 1'b0);
        send_text("{\"x\":{\"\":1},\"\":true }", 1'b0);
        send_text("{\"\"", 1'b0);
        configure(128'd0, 5'd0, MODE_RAW, 12'd0);
        send_text("{\"\":\"abc\"}", 1'b0);
        configure(128'd0, 5'd0, 2'd3, 12'd2);
        send_text("{\"\":\"abc\"}", 1'b0);
    endtask

    task automatic test_key_edges();
        configure(pack_key("abcdefghijklmnop"), 5'd16, MODE_RAW, 12'd3);
        send_text("{\"abcdefghijklmnop\":\"longvalue\"}", 1'b0);
        configure(pack_key("abcdefghijklmnop"), 5'd17, MODE_RAW, 12'd255);
        send_text("{\"abcdefghijklmnop\":1}", 1'b0);
        configure(pack_key("a\\\"b"), 5'd4, MODE_STR, 12'd255);
        send_text("{\"a\\\"b\":\"ok\"}", 1'b0);
        configure({64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF}, 5'd31, MODE_INT,
                  12'd4095);
        send_text("{\"k\":1}", 1'b0);
    endtask

    task automatic test_random_traffic();
        logic [127:0] k;
        logic [4:0]   len;
        logic [11:0]  lim;
        int           sent;
        for (int p = 0; p < 6; p++) begin
            k = {$urandom, $urandom, $urandom, $urandom};
            case ($urandom_range(0, 5))
                0: len = 5'd0;
                1: len = 5'd16;
                2: len = 5'($urandom_range(17, 31));
                default: len = 5'($urandom_range(1, 4));
            endcase
            for (int i = 0; i < 16 && i < len; i++) k[8*i +: 8] = 8'("a" + $urandom_range(0, 3));
            case ($urandom_range(0, 3))
                0: lim = 12'd4095;
                1: lim = 12'd0;
                default: lim = 12'($urandom_range(1, 12));
            endcase
            configure(k, len, 2'($urandom_range(0, 2)), lim);
            quiet = (p == 5);
            sent = n_sent;
            while (n_sent - sent < 40) begin
                if ($urandom_range(0, 9) == 0) send_noise();
                else send_random_object();
            end
        end
    endtask

    initial begin
        errors = 0;
        idle_cycles = 0;
        quiet = 1'b0;
        rx_stall = 0;
        n_sent = 0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        in_byte = '0;
        in_last = 1'b0;
        out_ready = 1'b0;
        key_bits = '0;
        key_len = '0;
        xmode = MODE_STR;
        byte_limit = 12'd255;
        clear_parser();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_string_mode();
        test_int_mode();
        test_raw_mode();
        test_key_edges();
        test_random_traffic();
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

endmodule
